FILE: design/lzwbp_pkg.sv
package lzwbp_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int HASH_SLOTS_DEF   = 8192;   // must be a power of two

    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = 5;
    localparam int RES_IDX_W   = 4;
    localparam int CHAR_W      = 16;
    localparam int SYM_W       = 16;
    localparam int BPS_W       = 5;
    localparam int POS_W       = 5;
    localparam int CW_W        = 4;
    localparam int CD_W        = 16;
    localparam int SHCNT_W     = 5;

    localparam logic [BPS_W-1:0]   BPS_RESET  = 5'd16;
    localparam logic [BPS_W-1:0]   BPS_MAX    = 5'd16;
    localparam logic [CW_W-1:0]    CW_RESET   = 4'd2;
    localparam logic [CW_W-1:0]    CW_MAX     = 4'd15;
    localparam logic [CD_W-1:0]    CD_RESET   = 16'd2;
    localparam logic [CHAR_W-1:0]  END_CODE   = 16'd2;
    localparam logic [CHAR_W-1:0]  MARK_SHORT = 16'd0;
    localparam logic [CHAR_W-1:0]  MARK_LONG  = 16'd1;
    localparam logic [CHAR_W-1:0]  CHAR_LIMIT = 16'd256;
    localparam logic [SHCNT_W-1:0] SHORT_BITS = 5'd8;
    localparam logic [SHCNT_W-1:0] LONG_BITS  = 5'd16;
    localparam int                 FIRST_CODE = 3;

    localparam logic [15:0] HASH_MUL_PREFIX = 16'd40503;
    localparam logic [21:0] HASH_MUL_CHAR   = 22'd2654435;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HMUL,
        S_HADD,
        S_PROBE,
        S_CHECK,
        S_PHRASE,
        S_EMIT_RD,
        S_EMIT_DEC,
        S_SHIFT,
        S_LIT_CHAR,
        S_EN_LIT,
        S_EN_LAST,
        S_ALLOC,
        S_TAIL,
        S_END,
        S_PAD,
        S_DRAIN
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_HMUL,
        OP_HADD,
        OP_PROBE,
        OP_CHECK,
        OP_PHRASE,
        OP_EMIT_RD,
        OP_EMIT_DEC,
        OP_SHIFT,
        OP_LIT_CHAR,
        OP_EN_LIT,
        OP_EN_LAST,
        OP_ALLOC,
        OP_END,
        OP_PAD,
        OP_DRAIN,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   phase2;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic miss_end;
        logic present;
        logic phrase_zero;
        logic pend;
        logic shift_done;
        logic pad_done;
        logic drain_done;
        logic clear_done;
        logic last_item;
    } dp_status_t;

endpackage

FILE: design/lzwbp_ram.sv
module lzwbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lzwbp_datapath.sv
module lzwbp_datapath #(
    parameter int DICT_ENTRIES = lzwbp_pkg::DICT_ENTRIES_DEF,
    parameter int HASH_SLOTS   = lzwbp_pkg::HASH_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lzwbp_pkg::dp_cmd_t             cmd,
    output lzwbp_pkg::dp_status_t          status,
    input  logic [lzwbp_pkg::CHAR_W-1:0]   char_code,
    input  logic                           last_char,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lzwbp_pkg::BPS_W-1:0]    bits_per_symbol,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lzwbp_pkg::SYM_W-1:0]    symbol,
    output logic                           last_symbol,
    output logic                           dictionary_overflow
);

    localparam int CODE_W = $clog2(DICT_ENTRIES);
    localparam int HB     = $clog2(HASH_SLOTS);
    localparam int TBL_W  = 1 + CODE_W + lzwbp_pkg::CHAR_W + CODE_W;
    localparam int SWEEP  = (HASH_SLOTS > DICT_ENTRIES) ? HASH_SLOTS : DICT_ENTRIES;
    localparam int CLR_W  = $clog2(SWEEP);

    localparam int CW  = lzwbp_pkg::CHAR_W;
    localparam int RW  = lzwbp_pkg::RES_CNT_W;
    localparam int RIW = lzwbp_pkg::RES_IDX_W;

    // stream state
    logic [CODE_W-1:0]             phrase_code_reg, phrase_code_next;
    logic [CW-1:0]                 phrase_char_reg, phrase_char_next;
    logic                          present_reg, present_next;
    logic [CODE_W:0]               next_code_reg, next_code_next;
    logic [lzwbp_pkg::CD_W-1:0]    cd_reg, cd_next;
    logic [lzwbp_pkg::CW_W-1:0]    cw_reg, cw_next;
    logic [lzwbp_pkg::SYM_W-1:0]   acc_reg, acc_next;
    logic [lzwbp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                          ovf_reg, ovf_next;
    logic [lzwbp_pkg::BPS_W-1:0]   bps_reg, bps_next;

    // per-item work registers
    logic [CW-1:0]                 cur_char_reg, cur_char_next;
    logic                          cur_last_reg, cur_last_next;
    logic [CODE_W-1:0]             ccode_reg, ccode_next;
    logic [CODE_W-1:0]             key_prefix_reg, key_prefix_next;
    logic [CW-1:0]                 key_ch_reg, key_ch_next;
    logic [HB-1:0]                 p1_reg, p1_next;
    logic [HB-1:0]                 p2_reg, p2_next;
    logic [HB-1:0]                 probe_idx_reg, probe_idx_next;
    logic [HB-1:0]                 probe_cnt_reg, probe_cnt_next;
    logic                          slot_free_reg, slot_free_next;
    logic [CW-1:0]                 shifter_reg, shifter_next;
    logic [lzwbp_pkg::SHCNT_W-1:0] shcnt_reg, shcnt_next;
    logic [RW-1:0]                 res_cnt_reg, res_cnt_next;
    logic [RW-1:0]                 drain_idx_reg, drain_idx_next;
    logic [CLR_W-1:0]              clear_cnt_reg, clear_cnt_next;

    logic [lzwbp_pkg::SYM_W-1:0]   sym_buf_reg [lzwbp_pkg::MAX_RESULTS];
    logic                          last_buf_reg [lzwbp_pkg::MAX_RESULTS];

    logic                          buf_we;
    logic [RIW-1:0]                buf_widx;
    logic [lzwbp_pkg::SYM_W-1:0]   buf_wsym;
    logic                          buf_wlast;

    logic                          tbl_we;
    logic [HB-1:0]                 tbl_addr;
    logic [TBL_W-1:0]              tbl_wdata;
    logic [TBL_W-1:0]              tbl_rdata;
    logic                          lp_we;
    logic [CODE_W-1:0]             lp_addr;
    logic                          lp_wdata;
    logic                          lp_rdata;

    logic                          ent_valid;
    logic [CODE_W-1:0]             ent_prefix;
    logic [CW-1:0]                 ent_ch;
    logic [CODE_W-1:0]             ent_code;
    logic                          hit;
    logic                          miss_end;
    logic                          pend;
    logic [3:0]                    eff_m1;
    logic                          pos_at_end;

    logic [CODE_W+15:0]            prod_p;
    logic [37:0]                   prod_c;
    logic [HB:0]                   hsum;

    logic                          put_en;
    logic                          put_bit;
    logic                          put_last;
    logic                          enl;
    logic [lzwbp_pkg::SYM_W-1:0]   acc_shift;
    logic [lzwbp_pkg::CD_W-1:0]    cd_dec;

    lzwbp_ram #(.WIDTH(TBL_W), .DEPTH(HASH_SLOTS)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    lzwbp_ram #(.WIDTH(1), .DEPTH(DICT_ENTRIES)) u_pending (
        .clk   (clk),
        .we    (lp_we),
        .addr  (lp_addr),
        .wdata (lp_wdata),
        .rdata (lp_rdata)
    );

    assign ent_valid  = tbl_rdata[TBL_W-1];
    assign ent_prefix = tbl_rdata[TBL_W-2 -: CODE_W];
    assign ent_ch     = tbl_rdata[CODE_W+CW-1:CODE_W];
    assign ent_code   = tbl_rdata[CODE_W-1:0];

    assign hit      = ent_valid && (ent_prefix == key_prefix_reg) && (ent_ch == key_ch_reg);
    assign miss_end = !hit && (!ent_valid || (probe_cnt_reg == HB'(HASH_SLOTS - 1)));
    assign pend     = (phrase_code_reg == '0) || lp_rdata;

    always_comb
    begin
        if (bps_reg == '0)
        begin
            eff_m1 = 4'd0;
        end
        else if (bps_reg > lzwbp_pkg::BPS_MAX)
        begin
            eff_m1 = 4'd15;
        end
        else
        begin
            eff_m1 = 4'(bps_reg - 5'd1);
        end
    end

    assign pos_at_end = pos_reg >= {1'b0, eff_m1};

    assign prod_p = key_prefix_reg * lzwbp_pkg::HASH_MUL_PREFIX;
    assign prod_c = key_ch_reg * lzwbp_pkg::HASH_MUL_CHAR;
    assign hsum   = {1'b0, p1_reg} + {1'b0, p2_reg};

    assign status.hit         = hit;
    assign status.miss_end    = miss_end;
    assign status.present     = present_reg;
    assign status.phrase_zero = (phrase_code_reg == '0);
    assign status.pend        = pend;
    assign status.shift_done  = (shcnt_reg == lzwbp_pkg::SHCNT_W'(1));
    assign status.pad_done    = pos_at_end;
    assign status.drain_done  = (drain_idx_reg == res_cnt_reg);
    assign status.clear_done  = (clear_cnt_reg == CLR_W'(SWEEP - 1));
    assign status.last_item   = cur_last_reg;

    assign cfg_ready           = 1'b1;
    assign out_valid           = (cmd.op == lzwbp_pkg::OP_DRAIN) && (drain_idx_reg != res_cnt_reg);
    assign symbol              = sym_buf_reg[drain_idx_reg[RIW-1:0]];
    assign last_symbol         = last_buf_reg[drain_idx_reg[RIW-1:0]];
    assign dictionary_overflow = ovf_reg;

    always_comb
    begin
        phrase_code_next = phrase_code_reg;
        phrase_char_next = phrase_char_reg;
        present_next     = present_reg;
        next_code_next   = next_code_reg;
        cd_next          = cd_reg;
        cw_next          = cw_reg;
        acc_next         = acc_reg;
        pos_next         = pos_reg;
        ovf_next         = ovf_reg;
        bps_next         = (cfg_valid && cfg_ready) ? bits_per_symbol : bps_reg;
        cur_char_next    = cur_char_reg;
        cur_last_next    = cur_last_reg;
        ccode_next       = ccode_reg;
        key_prefix_next  = key_prefix_reg;
        key_ch_next      = key_ch_reg;
        p1_next          = p1_reg;
        p2_next          = p2_reg;
        probe_idx_next   = probe_idx_reg;
        probe_cnt_next   = probe_cnt_reg;
        slot_free_next   = slot_free_reg;
        shifter_next     = shifter_reg;
        shcnt_next       = shcnt_reg;
        res_cnt_next     = res_cnt_reg;
        drain_idx_next   = drain_idx_reg;
        clear_cnt_next   = clear_cnt_reg;

        tbl_we    = 1'b0;
        tbl_addr  = probe_idx_reg;
        tbl_wdata = '0;
        lp_we     = 1'b0;
        lp_addr   = phrase_code_reg;
        lp_wdata  = 1'b0;
        put_en    = 1'b0;
        put_bit   = 1'b0;
        put_last  = 1'b0;
        enl       = 1'b0;
        buf_we    = 1'b0;
        buf_widx  = res_cnt_reg[RIW-1:0];
        buf_wsym  = '0;
        buf_wlast = 1'b0;
        acc_shift = '0;
        cd_dec    = '0;

        case (cmd.op)
            lzwbp_pkg::OP_TAKE:
            begin
                cur_char_next   = char_code;
                cur_last_next   = last_char;
                key_prefix_next = '0;
                key_ch_next     = char_code;
                res_cnt_next    = '0;
                drain_idx_next  = '0;
            end
            lzwbp_pkg::OP_HMUL:
            begin
                p1_next = prod_p[HB-1:0];
                p2_next = prod_c[HB-1:0];
            end
            lzwbp_pkg::OP_HADD:
            begin
                probe_idx_next = hsum[HB-1:0];
                probe_cnt_next = '0;
            end
            lzwbp_pkg::OP_PROBE:
            begin
                tbl_addr = probe_idx_reg;
            end
            lzwbp_pkg::OP_CHECK:
            begin
                if (!hit && !miss_end)
                begin
                    probe_idx_next = probe_idx_reg + HB'(1);
                    probe_cnt_next = probe_cnt_reg + HB'(1);
                end
                if (!cmd.phase2)
                begin
                    if (hit)
                    begin
                        ccode_next = ent_code;
                    end
                    else if (miss_end)
                    begin
                        if (next_code_reg >= (CODE_W+1)'(DICT_ENTRIES))
                        begin
                            ovf_next   = 1'b1;
                            ccode_next = '0;
                        end
                        else
                        begin
                            next_code_next = next_code_reg + (CODE_W+1)'(1);
                            if (!ent_valid)
                            begin
                                ccode_next = next_code_reg[CODE_W-1:0];
                                tbl_we     = 1'b1;
                                tbl_wdata  = {1'b1, {CODE_W{1'b0}}, cur_char_reg,
                                              next_code_reg[CODE_W-1:0]};
                                lp_we      = 1'b1;
                                lp_addr    = next_code_reg[CODE_W-1:0];
                                lp_wdata   = 1'b1;
                            end
                            else
                            begin
                                ovf_next   = 1'b1;
                                ccode_next = '0;
                            end
                        end
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        phrase_code_next = ent_code;
                        phrase_char_next = cur_char_reg;
                    end
                    else if (miss_end)
                    begin
                        slot_free_next = !ent_valid;
                    end
                end
            end
            lzwbp_pkg::OP_PHRASE:
            begin
                if (!present_reg)
                begin
                    phrase_code_next = ccode_reg;
                    phrase_char_next = cur_char_reg;
                    present_next     = 1'b1;
                end
                else
                begin
                    key_prefix_next = phrase_code_reg;
                    key_ch_next     = cur_char_reg;
                end
            end
            lzwbp_pkg::OP_EMIT_RD:
            begin
                lp_addr = phrase_code_reg;
            end
            lzwbp_pkg::OP_EMIT_DEC:
            begin
                shcnt_next = {1'b0, cw_reg};
                if (pend)
                begin
                    shifter_next = (phrase_char_reg >= lzwbp_pkg::CHAR_LIMIT) ?
                                   lzwbp_pkg::MARK_LONG : lzwbp_pkg::MARK_SHORT;
                end
                else
                begin
                    shifter_next = '0;
                    shifter_next[CODE_W-1:0] = phrase_code_reg;
                end
            end
            lzwbp_pkg::OP_SHIFT:
            begin
                put_en       = 1'b1;
                put_bit      = shifter_reg[0];
                shifter_next = shifter_reg >> 1;
                shcnt_next   = shcnt_reg - lzwbp_pkg::SHCNT_W'(1);
            end
            lzwbp_pkg::OP_LIT_CHAR:
            begin
                shifter_next = phrase_char_reg;
                shcnt_next   = (phrase_char_reg < lzwbp_pkg::CHAR_LIMIT) ?
                               lzwbp_pkg::SHORT_BITS : lzwbp_pkg::LONG_BITS;
            end
            lzwbp_pkg::OP_EN_LIT:
            begin
                enl = 1'b1;
                if (phrase_code_reg != '0)
                begin
                    lp_we    = 1'b1;
                    lp_addr  = phrase_code_reg;
                    lp_wdata = 1'b0;
                end
            end
            lzwbp_pkg::OP_EN_LAST:
            begin
                enl = 1'b1;
            end
            lzwbp_pkg::OP_ALLOC:
            begin
                if (next_code_reg >= (CODE_W+1)'(DICT_ENTRIES))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    next_code_next = next_code_reg + (CODE_W+1)'(1);
                    if (phrase_code_reg != '0)
                    begin
                        if (slot_free_reg)
                        begin
                            tbl_we    = 1'b1;
                            tbl_wdata = {1'b1, phrase_code_reg, cur_char_reg,
                                         next_code_reg[CODE_W-1:0]};
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                phrase_code_next = ccode_reg;
                phrase_char_next = cur_char_reg;
            end
            lzwbp_pkg::OP_END:
            begin
                shifter_next = lzwbp_pkg::END_CODE;
                shcnt_next   = {1'b0, cw_reg};
            end
            lzwbp_pkg::OP_PAD:
            begin
                put_en   = 1'b1;
                put_bit  = 1'b0;
                put_last = 1'b1;
            end
            lzwbp_pkg::OP_DRAIN:
            begin
                if (out_valid && !out_stall)
                begin
                    drain_idx_next = drain_idx_reg + RW'(1);
                end
            end
            lzwbp_pkg::OP_CLEAR:
            begin
                tbl_we           = 1'b1;
                tbl_addr         = clear_cnt_reg[HB-1:0];
                tbl_wdata        = '0;
                lp_we            = 1'b1;
                lp_addr          = clear_cnt_reg[CODE_W-1:0];
                lp_wdata         = 1'b0;
                clear_cnt_next   = status.clear_done ? '0 : clear_cnt_reg + CLR_W'(1);
                phrase_code_next = '0;
                phrase_char_next = '0;
                present_next     = 1'b0;
                next_code_next   = (CODE_W+1)'(lzwbp_pkg::FIRST_CODE);
                cd_next          = lzwbp_pkg::CD_RESET;
                cw_next          = lzwbp_pkg::CW_RESET;
                acc_next         = '0;
                pos_next         = '0;
                ovf_next         = 1'b0;
            end
            default:
            begin
            end
        endcase

        // one packed bit, MSB first into the symbol
        if (put_en)
        begin
            acc_shift = {acc_reg[lzwbp_pkg::SYM_W-2:0], put_bit};
            if (pos_at_end)
            begin
                pos_next  = '0;
                acc_next  = '0;
                buf_wsym  = acc_shift;
                buf_wlast = put_last;
                if (res_cnt_reg < RW'(lzwbp_pkg::MAX_RESULTS))
                begin
                    buf_we       = 1'b1;
                    buf_widx     = res_cnt_reg[RIW-1:0];
                    res_cnt_next = res_cnt_reg + RW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                    if (put_last)
                    begin
                        buf_we   = 1'b1;
                        buf_widx = RIW'(lzwbp_pkg::MAX_RESULTS - 1);
                    end
                end
            end
            else
            begin
                pos_next = pos_reg + lzwbp_pkg::POS_W'(1);
                acc_next = acc_shift;
            end
        end

        // code width growth
        if (enl)
        begin
            cd_dec = (cd_reg != '0) ? cd_reg - lzwbp_pkg::CD_W'(1) : cd_reg;
            if (cd_dec == '0)
            begin
                cd_next = lzwbp_pkg::CD_W'(1) << cw_reg;
                if (cw_reg < lzwbp_pkg::CW_MAX)
                begin
                    cw_next = cw_reg + lzwbp_pkg::CW_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                cd_next = cd_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phrase_code_reg <= '0;
            phrase_char_reg <= '0;
            present_reg     <= 1'b0;
            next_code_reg   <= (CODE_W+1)'(lzwbp_pkg::FIRST_CODE);
            cd_reg          <= lzwbp_pkg::CD_RESET;
            cw_reg          <= lzwbp_pkg::CW_RESET;
            acc_reg         <= '0;
            pos_reg         <= '0;
            ovf_reg         <= 1'b0;
            bps_reg         <= lzwbp_pkg::BPS_RESET;
            cur_last_reg    <= 1'b0;
            shcnt_reg       <= '0;
            res_cnt_reg     <= '0;
            drain_idx_reg   <= '0;
            clear_cnt_reg   <= '0;
        end
        else
        begin
            phrase_code_reg <= phrase_code_next;
            phrase_char_reg <= phrase_char_next;
            present_reg     <= present_next;
            next_code_reg   <= next_code_next;
            cd_reg          <= cd_next;
            cw_reg          <= cw_next;
            acc_reg         <= acc_next;
            pos_reg         <= pos_next;
            ovf_reg         <= ovf_next;
            bps_reg         <= bps_next;
            cur_last_reg    <= cur_last_next;
            shcnt_reg       <= shcnt_next;
            res_cnt_reg     <= res_cnt_next;
            drain_idx_reg   <= drain_idx_next;
            clear_cnt_reg   <= clear_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_char_reg   <= cur_char_next;
        ccode_reg      <= ccode_next;
        key_prefix_reg <= key_prefix_next;
        key_ch_reg     <= key_ch_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        probe_idx_reg  <= probe_idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        slot_free_reg  <= slot_free_next;
        shifter_reg    <= shifter_next;
        if (buf_we)
        begin
            sym_buf_reg[buf_widx]  <= buf_wsym;
            last_buf_reg[buf_widx] <= buf_wlast;
        end
    end

endmodule

FILE: design/lzwbp_ctrl.sv
module lzwbp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lzwbp_pkg::dp_status_t status,
    output lzwbp_pkg::dp_cmd_t    cmd
);

    lzwbp_pkg::ctrl_state_t state_reg, state_next;
    lzwbp_pkg::ctrl_state_t ret_reg, ret_next;
    logic                   flush_reg, flush_next;
    logic                   phase2_reg, phase2_next;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        flush_next  = flush_reg;
        phase2_next = phase2_reg;
        case (state_reg)
            lzwbp_pkg::S_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = lzwbp_pkg::S_IDLE;
                end
            end
            lzwbp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = lzwbp_pkg::S_HMUL;
                    phase2_next = 1'b0;
                    flush_next  = 1'b0;
                end
            end
            lzwbp_pkg::S_HMUL:  state_next = lzwbp_pkg::S_HADD;
            lzwbp_pkg::S_HADD:  state_next = lzwbp_pkg::S_PROBE;
            lzwbp_pkg::S_PROBE: state_next = lzwbp_pkg::S_CHECK;
            lzwbp_pkg::S_CHECK:
            begin
                if (status.hit)
                begin
                    state_next = phase2_reg ? lzwbp_pkg::S_TAIL : lzwbp_pkg::S_PHRASE;
                end
                else if (status.miss_end)
                begin
                    state_next = phase2_reg ? lzwbp_pkg::S_EMIT_RD : lzwbp_pkg::S_PHRASE;
                end
                else
                begin
                    state_next = lzwbp_pkg::S_PROBE;
                end
            end
            lzwbp_pkg::S_PHRASE:
            begin
                if (!status.present)
                begin
                    state_next = lzwbp_pkg::S_TAIL;
                end
                else if (status.phrase_zero)
                begin
                    state_next = lzwbp_pkg::S_EMIT_RD;
                end
                else
                begin
                    phase2_next = 1'b1;
                    state_next  = lzwbp_pkg::S_HMUL;
                end
            end
            lzwbp_pkg::S_EMIT_RD: state_next = lzwbp_pkg::S_EMIT_DEC;
            lzwbp_pkg::S_EMIT_DEC:
            begin
                ret_next   = status.pend ? lzwbp_pkg::S_LIT_CHAR : lzwbp_pkg::S_EN_LAST;
                state_next = lzwbp_pkg::S_SHIFT;
            end
            lzwbp_pkg::S_SHIFT:
            begin
                if (status.shift_done)
                begin
                    state_next = ret_reg;
                end
            end
            lzwbp_pkg::S_LIT_CHAR:
            begin
                ret_next   = lzwbp_pkg::S_EN_LIT;
                state_next = lzwbp_pkg::S_SHIFT;
            end
            lzwbp_pkg::S_EN_LIT: state_next = lzwbp_pkg::S_EN_LAST;
            lzwbp_pkg::S_EN_LAST:
            begin
                state_next = flush_reg ? lzwbp_pkg::S_END : lzwbp_pkg::S_ALLOC;
            end
            lzwbp_pkg::S_ALLOC: state_next = lzwbp_pkg::S_TAIL;
            lzwbp_pkg::S_TAIL:
            begin
                if (status.last_item)
                begin
                    flush_next = 1'b1;
                    state_next = lzwbp_pkg::S_EMIT_RD;
                end
                else
                begin
                    state_next = lzwbp_pkg::S_DRAIN;
                end
            end
            lzwbp_pkg::S_END:
            begin
                ret_next   = lzwbp_pkg::S_PAD;
                state_next = lzwbp_pkg::S_SHIFT;
            end
            lzwbp_pkg::S_PAD:
            begin
                if (status.pad_done)
                begin
                    state_next = lzwbp_pkg::S_DRAIN;
                end
            end
            lzwbp_pkg::S_DRAIN:
            begin
                if (status.drain_done)
                begin
                    state_next = status.last_item ? lzwbp_pkg::S_CLEAR : lzwbp_pkg::S_IDLE;
                end
            end
            default: state_next = lzwbp_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.phase2 = phase2_reg;
        in_stall   = (state_reg != lzwbp_pkg::S_IDLE);
        case (state_reg)
            lzwbp_pkg::S_CLEAR:    cmd.op = lzwbp_pkg::OP_CLEAR;
            lzwbp_pkg::S_IDLE:     cmd.op = in_valid ? lzwbp_pkg::OP_TAKE : lzwbp_pkg::OP_NONE;
            lzwbp_pkg::S_HMUL:     cmd.op = lzwbp_pkg::OP_HMUL;
            lzwbp_pkg::S_HADD:     cmd.op = lzwbp_pkg::OP_HADD;
            lzwbp_pkg::S_PROBE:    cmd.op = lzwbp_pkg::OP_PROBE;
            lzwbp_pkg::S_CHECK:    cmd.op = lzwbp_pkg::OP_CHECK;
            lzwbp_pkg::S_PHRASE:   cmd.op = lzwbp_pkg::OP_PHRASE;
            lzwbp_pkg::S_EMIT_RD:  cmd.op = lzwbp_pkg::OP_EMIT_RD;
            lzwbp_pkg::S_EMIT_DEC: cmd.op = lzwbp_pkg::OP_EMIT_DEC;
            lzwbp_pkg::S_SHIFT:    cmd.op = lzwbp_pkg::OP_SHIFT;
            lzwbp_pkg::S_LIT_CHAR: cmd.op = lzwbp_pkg::OP_LIT_CHAR;
            lzwbp_pkg::S_EN_LIT:   cmd.op = lzwbp_pkg::OP_EN_LIT;
            lzwbp_pkg::S_EN_LAST:  cmd.op = lzwbp_pkg::OP_EN_LAST;
            lzwbp_pkg::S_ALLOC:    cmd.op = lzwbp_pkg::OP_ALLOC;
            lzwbp_pkg::S_END:      cmd.op = lzwbp_pkg::OP_END;
            lzwbp_pkg::S_PAD:      cmd.op = lzwbp_pkg::OP_PAD;
            lzwbp_pkg::S_DRAIN:    cmd.op = lzwbp_pkg::OP_DRAIN;
            default:               cmd.op = lzwbp_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lzwbp_pkg::S_CLEAR;
            ret_reg    <= lzwbp_pkg::S_IDLE;
            flush_reg  <= 1'b0;
            phase2_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            flush_reg  <= flush_next;
            phase2_reg <= phase2_next;
        end
    end

endmodule

FILE: design/lzw_bitpack_compressor.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    char_code, last_char
// output    out        out_valid / out_stall  symbol, last_symbol, dictionary_overflow
// config    in         cfg_valid / cfg_ready  bits_per_symbol
//
// One request at a time: one or two hash lookups, each a hash multiply and add and then
// table probes until a hit, an empty slot or a full sweep; then the packed bits one after
// another, then the symbols delivered. The single-port phrase table and the serial bit packer set the pace.
// After reset and after each final request, a clearing pass over
// max(HASH_SLOTS, DICT_ENTRIES) table entries runs with in_stall high.
// Symbols of a request are held until out_stall is low; no new request is taken meanwhile.
module lzw_bitpack_compressor #(
    parameter int DICT_ENTRIES = lzwbp_pkg::DICT_ENTRIES_DEF,
    parameter int HASH_SLOTS   = lzwbp_pkg::HASH_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [lzwbp_pkg::CHAR_W-1:0] char_code,
    input  logic                         last_char,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lzwbp_pkg::SYM_W-1:0]  symbol,
    output logic                         last_symbol,
    output logic                         dictionary_overflow,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lzwbp_pkg::BPS_W-1:0]  bits_per_symbol
);

    lzwbp_pkg::dp_cmd_t    cmd;
    lzwbp_pkg::dp_status_t status;

    lzwbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lzwbp_datapath #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .HASH_SLOTS   (HASH_SLOTS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .char_code           (char_code),
        .last_char           (last_char),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .bits_per_symbol     (bits_per_symbol),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .symbol              (symbol),
        .last_symbol         (last_symbol),
        .dictionary_overflow (dictionary_overflow)
    );

endmodule

FILE: design/lzwbp_checker.sv
module lzwbp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [lzwbp_pkg::CHAR_W-1:0] char_code,
    input logic                         last_char,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [lzwbp_pkg::SYM_W-1:0]  symbol,
    input logic                         last_symbol,
    input logic                         dictionary_overflow,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [lzwbp_pkg::BPS_W-1:0]  bits_per_symbol
);

    a_no_take_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while symbols pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken back to back");

    a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_symbol) |=> !out_valid)
        else $error("symbol after final symbol");

    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid)) |-> $stable(dictionary_overflow))
        else $error("overflow flag changed within a burst");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(symbol)))
        else $error("stalled output changed");

endmodule

bind lzw_bitpack_compressor lzwbp_checker u_checker (.*);
